// ===== rtl/pls_pkg.sv =====
`default_nettype none

package pls_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int POS_W    = 8;
	localparam int DATA_W   = 32;
	localparam int MODE_W   = 3;
	localparam int STAT_W   = 3;
	localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	typedef enum logic [MODE_W-1:0] {
		MODE_INS_FRONT = 3'd0,
		MODE_INS_BACK  = 3'd1,
		MODE_INS_AT    = 3'd2,
		MODE_DEL_FRONT = 3'd3,
		MODE_DEL_BACK  = 3'd4,
		MODE_DEL_AT    = 3'd5,
		MODE_LIST_FWD  = 3'd6,
		MODE_LIST_REV  = 3'd7
	} mode_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK     = 3'd0,
		STAT_BELOW  = 3'd1,
		STAT_BEYOND = 3'd2,
		STAT_EMPTY  = 3'd3,
		STAT_FULL   = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		OP_HOLD    = 3'd0,
		OP_INSERT  = 3'd1,
		OP_DELETE  = 3'd2,
		OP_ROT_FWD = 3'd3,
		OP_ROT_REV = 3'd4
	} cell_op_t;

	typedef struct packed {
		cell_op_t                  op;
		logic [IDX_W-1:0]          idx;
		logic [CNT_W-1:0]          count;
		logic signed [DATA_W-1:0]  value;
	} cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/positional_list_store_unit.sv =====
// An insert or delete gives its status beat in the cycle after acceptance. A listing of n
// elements enters the listing state, then gives one beat per cycle while out_stall is low.
// Throughput: one item per cycle for inserts/deletes while out_stall is low; a listing
// holds the input until its last beat; positional shifts move the row, listings rotate it.
// Reset (arst_n low, asynchronous) empties the list; stored values are undefined until written.
`default_nettype none

module positional_list_store_unit (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   in_valid,
	output logic                                  in_stall,
	input  wire  [pls_pkg::MODE_W-1:0]            mode,
	input  wire  signed [pls_pkg::DATA_W-1:0]     value,
	input  wire  [pls_pkg::POS_W-1:0]             position,
	output logic                                  out_valid,
	input  wire                                   out_stall,
	output logic signed [pls_pkg::DATA_W-1:0]     element,
	output logic [pls_pkg::STAT_W-1:0]            status,
	output logic [pls_pkg::CNT_W-1:0]             length,
	output logic                                  last
);

	typedef enum logic {
		ST_IDLE,
		ST_LIST
	} state_t;

	state_t                               state_q;
	logic [pls_pkg::CNT_W-1:0]            count_q;
	logic [pls_pkg::CNT_W-1:0]            lcnt_q;
	logic                                 rev_q;
	logic                                 out_valid_q;
	logic signed [pls_pkg::DATA_W-1:0]    element_q;
	logic [pls_pkg::STAT_W-1:0]           status_q;
	logic [pls_pkg::CNT_W-1:0]            length_q;
	logic                                 last_q;

	logic                                 out_free;
	logic                                 in_acc;
	pls_pkg::status_t                     status_c;
	logic                                 ins_ok;
	logic                                 del_ok;
	logic                                 is_list;
	logic [pls_pkg::IDX_W-1:0]            idx_c;
	logic [pls_pkg::CNT_W-1:0]            count_next;
	logic [pls_pkg::CMP_W-1:0]            pos_w;
	logic [pls_pkg::CMP_W-1:0]            cnt_w;
	logic                                 is_full;
	logic                                 list_last;
	logic [pls_pkg::IDX_W-1:0]            tail_idx;
	logic signed [pls_pkg::DATA_W-1:0]    tail_data;
	pls_pkg::cell_ctl_t                   ctl;

	logic signed [pls_pkg::DATA_W-1:0]    cell_data  [pls_pkg::CAPACITY];
	logic signed [pls_pkg::DATA_W-1:0]    left_data  [pls_pkg::CAPACITY];
	logic signed [pls_pkg::DATA_W-1:0]    right_data [pls_pkg::CAPACITY];

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE) || (out_valid_q && out_stall);
	assign in_acc   = in_valid && !in_stall;

	assign out_valid = out_valid_q;
	assign element   = element_q;
	assign status    = status_q;
	assign length    = length_q;
	assign last      = last_q;

	// command decode
	always_comb begin
		pos_w    = pls_pkg::CMP_W'(position);
		cnt_w    = pls_pkg::CMP_W'(count_q);
		is_full  = count_q == pls_pkg::CNT_W'(pls_pkg::CAPACITY);
		status_c = pls_pkg::STAT_OK;
		ins_ok   = 1'b0;
		del_ok   = 1'b0;
		is_list  = 1'b0;
		idx_c    = '0;
		unique case (mode) inside
			pls_pkg::MODE_INS_FRONT, pls_pkg::MODE_INS_BACK: begin
				idx_c = (mode == pls_pkg::MODE_INS_FRONT) ? '0 :
					pls_pkg::IDX_W'(count_q);
				if (is_full) begin
					status_c = pls_pkg::STAT_FULL;
				end else begin
					ins_ok = 1'b1;
				end
			end
			pls_pkg::MODE_INS_AT: begin
				idx_c = pls_pkg::IDX_W'(position - pls_pkg::POS_W'(1));
				if (pos_w == '0) begin
					status_c = pls_pkg::STAT_BELOW;
				end else if (pos_w > cnt_w + pls_pkg::CMP_W'(1)) begin
					status_c = pls_pkg::STAT_BEYOND;
				end else if (is_full) begin
					status_c = pls_pkg::STAT_FULL;
				end else begin
					ins_ok = 1'b1;
				end
			end
			pls_pkg::MODE_DEL_FRONT, pls_pkg::MODE_DEL_BACK: begin
				idx_c = (mode == pls_pkg::MODE_DEL_FRONT) ? '0 :
					pls_pkg::IDX_W'(count_q - pls_pkg::CNT_W'(1));
				if (count_q == '0) begin
					status_c = pls_pkg::STAT_EMPTY;
				end else begin
					del_ok = 1'b1;
				end
			end
			pls_pkg::MODE_DEL_AT: begin
				idx_c = pls_pkg::IDX_W'(position - pls_pkg::POS_W'(1));
				if (count_q == '0) begin
					status_c = pls_pkg::STAT_EMPTY;
				end else if (pos_w == '0) begin
					status_c = pls_pkg::STAT_BELOW;
				end else if (pos_w > cnt_w) begin
					status_c = pls_pkg::STAT_BEYOND;
				end else begin
					del_ok = 1'b1;
				end
			end
			pls_pkg::MODE_LIST_FWD, pls_pkg::MODE_LIST_REV: begin
				is_list = 1'b1;
				if (count_q == '0) begin
					status_c = pls_pkg::STAT_EMPTY;
				end
			end
			default: begin
				status_c = pls_pkg::STAT_OK;
			end
		endcase

		if (ins_ok) begin
			count_next = count_q + pls_pkg::CNT_W'(1);
		end else if (del_ok) begin
			count_next = count_q - pls_pkg::CNT_W'(1);
		end else begin
			count_next = count_q;
		end

		list_last = (lcnt_q + pls_pkg::CNT_W'(1)) == count_q;
		tail_idx  = pls_pkg::IDX_W'(count_q - pls_pkg::CNT_W'(1));
		tail_data = cell_data[tail_idx];
	end

	// row control, broadcast to every cell
	always_comb begin
		ctl.op    = pls_pkg::OP_HOLD;
		ctl.idx   = idx_c;
		ctl.count = count_q;
		ctl.value = value;
		if (in_acc && ins_ok) begin
			ctl.op = pls_pkg::OP_INSERT;
		end else if (in_acc && del_ok) begin
			ctl.op = pls_pkg::OP_DELETE;
		end else if (state_q == ST_LIST && out_free) begin
			ctl.op = rev_q ? pls_pkg::OP_ROT_REV : pls_pkg::OP_ROT_FWD;
		end
	end

	for (genvar g = 0; g < pls_pkg::CAPACITY; g++) begin : g_cell
		if (g == 0) begin : g_first
			assign left_data[g] = '0;
		end else begin : g_mid_l
			assign left_data[g] = cell_data[g-1];
		end
		if (g == pls_pkg::CAPACITY - 1) begin : g_final
			assign right_data[g] = '0;
		end else begin : g_mid_r
			assign right_data[g] = cell_data[g+1];
		end

		pls_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.self_idx   (pls_pkg::IDX_W'(g)),
			.left_data  (left_data[g]),
			.right_data (right_data[g]),
			.head_data  (cell_data[0]),
			.tail_data  (tail_data),
			.data_q     (cell_data[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			lcnt_q      <= '0;
			rev_q       <= 1'b0;
			out_valid_q <= 1'b0;
			element_q   <= '0;
			status_q    <= '0;
			length_q    <= '0;
			last_q      <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (is_list && count_q != '0) begin
							state_q     <= ST_LIST;
							lcnt_q      <= '0;
							rev_q       <= mode == pls_pkg::MODE_LIST_REV;
							out_valid_q <= 1'b0;
						end else begin
							out_valid_q <= 1'b1;
							element_q   <= '0;
							status_q    <= status_c;
							length_q    <= count_next;
							last_q      <= 1'b1;
							count_q     <= count_next;
						end
					end else if (out_free) begin
						out_valid_q <= 1'b0;
					end
				end
				ST_LIST: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						element_q   <= rev_q ? tail_data : cell_data[0];
						status_q    <= pls_pkg::STAT_OK;
						length_q    <= count_q;
						last_q      <= list_last;
						lcnt_q      <= lcnt_q + pls_pkg::CNT_W'(1);
						if (list_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q     <= ST_IDLE;
					out_valid_q <= 1'b0;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= pls_pkg::CNT_W'(pls_pkg::CAPACITY))
		else $error("element count beyond capacity");

	a_list_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LIST |-> count_q != '0 && lcnt_q < count_q)
		else $error("listing with no element left to send");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != pls_pkg::STAT_OK |-> last)
		else $error("status beat not marked last");

	a_list_count_held: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LIST |=> count_q == $past(count_q))
		else $error("count changed during a listing");
`endif

endmodule

`default_nettype wire

// ===== rtl/pls_cell.sv =====
`default_nettype none

module pls_cell (
	input  wire                                   clk,
	input  wire  pls_pkg::cell_ctl_t              ctl,
	input  wire  [pls_pkg::IDX_W-1:0]             self_idx,
	input  wire  signed [pls_pkg::DATA_W-1:0]     left_data,
	input  wire  signed [pls_pkg::DATA_W-1:0]     right_data,
	input  wire  signed [pls_pkg::DATA_W-1:0]     head_data,
	input  wire  signed [pls_pkg::DATA_W-1:0]     tail_data,
	output logic signed [pls_pkg::DATA_W-1:0]     data_q
);

	logic [pls_pkg::CNT_W-1:0] self_cnt;
	logic                      in_range;
	logic                      at_end;
	logic                      at_idx;
	logic                      past_idx;

	always_comb begin
		self_cnt = pls_pkg::CNT_W'(self_idx);
		in_range = self_cnt < ctl.count;
		at_end   = (self_cnt + pls_pkg::CNT_W'(1)) == ctl.count;
		at_idx   = self_idx == ctl.idx;
		past_idx = self_idx > ctl.idx;
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			pls_pkg::OP_INSERT: begin
				if (at_idx) begin
					data_q <= ctl.value;
				end else if (past_idx) begin
					data_q <= left_data;
				end
			end
			pls_pkg::OP_DELETE: begin
				if (at_idx || past_idx) begin
					data_q <= right_data;
				end
			end
			pls_pkg::OP_ROT_FWD: begin
				if (in_range) begin
					data_q <= at_end ? head_data : right_data;
				end
			end
			pls_pkg::OP_ROT_REV: begin
				if (in_range) begin
					data_q <= (self_idx == '0) ? tail_data : left_data;
				end
			end
			default: begin
				data_q <= data_q;
			end
		endcase
	end

endmodule

`default_nettype wire
